/* hdl/udf_pkg.sv */
package udf_pkg;

  localparam int DEF_MAX_DIGITS = 20;
  localparam int DEF_MAX_FIELD  = 63;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = 6;
  localparam int SHIFT_W    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_PRECISION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PAD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_JUSTIFY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_MODE    = 3'd4;

  localparam logic [6:0] PRECISION_RESET = 7'h7F;
  localparam logic [1:0] SIZE_MODE_RESET = 2'd3;
  localparam logic [1:0] SIZE_8          = 2'd0;
  localparam logic [1:0] SIZE_16         = 2'd1;

  localparam logic [SHIFT_W-1:0] SHIFTS_8  = 7'd8;
  localparam logic [SHIFT_W-1:0] SHIFTS_16 = 7'd16;
  localparam logic [SHIFT_W-1:0] SHIFTS_64 = 7'd64;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [6:0] precision;
    logic [5:0] field_width;
    logic       zero_pad;
    logic       left_justify;
    logic [1:0] size_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_SIZE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic scan;
    logic size;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic shift_last;
    logic scan_hit;
    logic total_zero;
    logic emit_last;
    logic slot_free;
  } status_t;

endpackage

/* hdl/udf_cfg.sv */
module udf_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [udf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [udf_pkg::CFG_DATA_W-1:0] cfg_data,
  output udf_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.precision    <= udf_pkg::PRECISION_RESET;
      cfg.field_width  <= '0;
      cfg.zero_pad     <= 1'b0;
      cfg.left_justify <= 1'b0;
      cfg.size_mode    <= udf_pkg::SIZE_MODE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        udf_pkg::REG_PRECISION:    cfg.precision    <= cfg_data[6:0];
        udf_pkg::REG_FIELD_WIDTH:  cfg.field_width  <= cfg_data[5:0];
        udf_pkg::REG_ZERO_PAD:     cfg.zero_pad     <= cfg_data[0];
        udf_pkg::REG_LEFT_JUSTIFY: cfg.left_justify <= cfg_data[0];
        udf_pkg::REG_SIZE_MODE:    cfg.size_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/udf_ctrl.sv */
module udf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  udf_pkg::status_t status,
  output udf_pkg::cmd_t    cmd
);

  udf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= udf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      udf_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = udf_pkg::ST_CONVERT;
        end
      end
      udf_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
        if (status.shift_last) state_next = udf_pkg::ST_SCAN;
      end
      udf_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_hit) state_next = udf_pkg::ST_SIZE;
      end
      udf_pkg::ST_SIZE: begin
        cmd.size   = 1'b1;
        state_next = udf_pkg::ST_EMIT;
      end
      udf_pkg::ST_EMIT: begin
        if (status.total_zero) begin
          state_next = udf_pkg::ST_IDLE;
        end else if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) state_next = udf_pkg::ST_IDLE;
        end
      end
      default: state_next = udf_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hdl/udf_dp.sv */
module udf_dp #(
  parameter int MAX_DIGITS = udf_pkg::DEF_MAX_DIGITS,
  parameter int MAX_FIELD  = udf_pkg::DEF_MAX_FIELD
) (
  input  logic                         clk,
  input  logic                         rst,
  input  udf_pkg::cfg_t                cfg,
  input  udf_pkg::cmd_t                cmd,
  output udf_pkg::status_t             status,
  input  logic [udf_pkg::VALUE_W-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [udf_pkg::CHAR_W-1:0]   m_tdata,
  output logic                         m_tlast
);

  localparam int DIW = $clog2(MAX_DIGITS);
  localparam int DCW = $clog2(MAX_DIGITS + 1);
  localparam int CW  = udf_pkg::CNT_W;
  localparam logic [CW-1:0] FIELD_MAX = CW'(MAX_FIELD);

  logic [udf_pkg::VALUE_W-1:0] value_sh;
  logic [udf_pkg::SHIFT_W-1:0] shift_cnt;
  logic [3:0]                  digit [MAX_DIGITS];
  logic [3:0]                  adj   [MAX_DIGITS];
  logic                        ovf;
  logic                        skip;
  logic [DIW-1:0]              scan_ptr;
  logic [DCW-1:0]              dcount;
  logic [CW-1:0]               body, pad, total, emit_k;

  // load-time values
  logic [udf_pkg::VALUE_W-1:0] masked, aligned;
  logic [udf_pkg::SHIFT_W-1:0] shifts;

  always_comb begin
    unique case (cfg.size_mode)
      udf_pkg::SIZE_8: begin
        masked  = {56'd0, s_tdata[7:0]};
        aligned = {s_tdata[7:0], 56'd0};
        shifts  = udf_pkg::SHIFTS_8;
      end
      udf_pkg::SIZE_16: begin
        masked  = {48'd0, s_tdata[15:0]};
        aligned = {s_tdata[15:0], 48'd0};
        shifts  = udf_pkg::SHIFTS_16;
      end
      default: begin
        masked  = s_tdata;
        aligned = s_tdata;
        shifts  = udf_pkg::SHIFTS_64;
      end
    endcase
  end

  logic          prec_given;
  logic [CW-1:0] prec_sat, width_sat, prec_eff, dcount_w, body_calc, pad_calc;

  assign prec_given = !cfg.precision[6];
  assign prec_sat   = (cfg.precision[5:0] > FIELD_MAX) ? FIELD_MAX : cfg.precision[5:0];
  assign width_sat  = (cfg.field_width > FIELD_MAX) ? FIELD_MAX : cfg.field_width;
  assign prec_eff   = prec_given ? prec_sat : '0;
  assign dcount_w   = CW'(dcount);
  assign body_calc  = (prec_eff > dcount_w) ? prec_eff : dcount_w;
  assign pad_calc   = (width_sat > body_calc) ? width_sat - body_calc : '0;

  // add-3 correction ahead of each shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digit[i] >= 4'd5) ? digit[i] + 4'd3 : digit[i];
    end
  end

  logic scan_hit;
  assign scan_hit = skip || ovf || (digit[scan_ptr] != 4'd0) || (scan_ptr == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_sh  <= aligned;
      shift_cnt <= shifts;
      ovf       <= 1'b0;
      skip      <= (masked == '0) && prec_given && (cfg.precision[5:0] == 6'd0);
      scan_ptr  <= DIW'(MAX_DIGITS - 1);
      for (int i = 0; i < MAX_DIGITS; i++) digit[i] <= 4'd0;
    end else if (cmd.shift) begin
      value_sh  <= {value_sh[udf_pkg::VALUE_W-2:0], 1'b0};
      shift_cnt <= shift_cnt - 1'b1;
      ovf       <= ovf | adj[MAX_DIGITS-1][3];
      digit[0]  <= {adj[0][2:0], value_sh[udf_pkg::VALUE_W-1]};
      for (int i = 1; i < MAX_DIGITS; i++) digit[i] <= {adj[i][2:0], adj[i-1][3]};
    end else if (cmd.scan) begin
      if (scan_hit) begin
        if (skip) dcount <= '0;
        else if (ovf) dcount <= DCW'(MAX_DIGITS);
        else dcount <= DCW'(scan_ptr) + DCW'(1);
      end else begin
        scan_ptr <= scan_ptr - 1'b1;
      end
    end else if (cmd.size) begin
      body   <= body_calc;
      pad    <= pad_calc;
      total  <= body_calc + pad_calc;
      emit_k <= '0;
    end else if (cmd.emit) begin
      emit_k <= emit_k + 1'b1;
    end
  end

  // character for the current position
  logic                      is_digit;
  logic [CW-1:0]             pos;
  logic [udf_pkg::CHAR_W-1:0] pad_char, digit_ch, ch;

  always_comb begin
    if (cfg.left_justify) begin
      is_digit = emit_k < body;
      pos      = body - CW'(1) - emit_k;
    end else begin
      is_digit = emit_k >= pad;
      pos      = total - CW'(1) - emit_k;
    end
    pad_char = (cfg.zero_pad && !prec_given && !cfg.left_justify) ?
               udf_pkg::CHAR_ZERO : udf_pkg::CHAR_SPACE;
    digit_ch = (pos < dcount_w) ? udf_pkg::CHAR_ZERO + {4'd0, digit[pos[DIW-1:0]]} :
               udf_pkg::CHAR_ZERO;
    ch = is_digit ? digit_ch : (cfg.left_justify ? udf_pkg::CHAR_SPACE : pad_char);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= ch;
      m_tlast <= (emit_k == total - CW'(1));
    end
  end

  assign status.shift_last = (shift_cnt == udf_pkg::SHIFT_W'(1));
  assign status.scan_hit   = scan_hit;
  assign status.total_zero = (total == '0);
  assign status.emit_last  = (emit_k == total - CW'(1));
  assign status.slot_free  = !m_tvalid || m_tready;

endmodule

/* hdl/unsigned_decimal_field_formatter_top.sv */
// Unsigned decimal field formatter: renders one unsigned value as %u text.
// Input beat (s_tvalid/s_tready/s_tdata) carries the 64-bit value; output
// beats (m_tvalid/m_tready/m_tdata/m_tlast) carry one ASCII character each,
// m_tlast on the final character of the field. A field of zero characters
// (zero value, precision 0, width 0) produces no output beat at all.
// Format registers are written on the cfg channel (cfg_index selects precision,
// field_width, zero_pad, left_justify, size_mode); cfg_ready is always high,
// and writes are meant for idle periods only.
// Steps per value: a load, then 8, 16 or 64 double-dabble shifts (size
// mode), a leading-digit scan over up to MAX_DIGITS positions, a sizing
// step, then one character per cycle (at most MAX_FIELD) while the output
// register is free; a new value is taken once the last character is in the
// output register.
// The emit step runs only while the output register is free or being
// drained, so a stalled receiver simply holds the current character.
// Reset (rst, synchronous) returns the controller to idle, clears the
// output valid and restores the register defaults.
module unsigned_decimal_field_formatter_top #(
  parameter int MAX_DIGITS = udf_pkg::DEF_MAX_DIGITS,
  parameter int MAX_FIELD  = udf_pkg::DEF_MAX_FIELD
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [udf_pkg::VALUE_W-1:0]    s_tdata,   // [63:0] value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [udf_pkg::CHAR_W-1:0]     m_tdata,   // [7:0] char_out
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [udf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [udf_pkg::CFG_DATA_W-1:0] cfg_data
);

  udf_pkg::cfg_t    cfg;
  udf_pkg::cmd_t    cmd;
  udf_pkg::status_t status;

  udf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  udf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  udf_dp #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* tb/udf_field_checker.sv */
module udf_field_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [udf_pkg::VALUE_W-1:0]    s_tdata,    // [63:0] value
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [udf_pkg::CHAR_W-1:0]     m_tdata,    // [7:0] char_out
  input  logic                           m_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [udf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [udf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             values_seen,
  output int                             chars_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [udf_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } char_beat_t;

  char_beat_t    text_q[$];
  udf_pkg::cfg_t fmt;
  int            err_n;
  int            value_n;
  int            char_n;

  // Build the expected %u text for one value under the current format.
  task automatic render_value(input logic [udf_pkg::VALUE_W-1:0] raw);
    logic [udf_pkg::VALUE_W-1:0] v;
    logic [3:0]                  digits [udf_pkg::DEF_MAX_DIGITS];
    logic                        prec_given;
    logic [udf_pkg::CHAR_W-1:0]  pad_ch;
    logic [udf_pkg::CHAR_W-1:0]  ch;
    int                          ndig;
    int                          prec;
    int                          width;
    int                          body;
    int                          pad;
    int                          total;
    int                          k;
    int                          pos;

    v = raw;
    if (fmt.size_mode == udf_pkg::SIZE_8) v = v & 64'hFF;
    else if (fmt.size_mode == udf_pkg::SIZE_16) v = v & 64'hFFFF;

    // sign bit of precision set: treated as not given
    prec_given = !fmt.precision[6];
    prec  = prec_given ? int'(fmt.precision[5:0]) : 0;
    width = int'(fmt.field_width);
    if (prec > udf_pkg::DEF_MAX_FIELD) prec = udf_pkg::DEF_MAX_FIELD;
    if (width > udf_pkg::DEF_MAX_FIELD) width = udf_pkg::DEF_MAX_FIELD;

    ndig = 0;
    if (!(v == 0 && prec_given && prec == 0)) begin
      do begin
        digits[ndig] = 4'(v % 10);
        ndig++;
        v = v / 10;
      end while (v != 0 && ndig < udf_pkg::DEF_MAX_DIGITS);
    end

    body = (prec_given && prec > ndig) ? prec : ndig;
    pad  = (width > body) ? width - body : 0;
    pad_ch = (fmt.zero_pad && !prec_given && !fmt.left_justify) ?
             udf_pkg::CHAR_ZERO : udf_pkg::CHAR_SPACE;
    total = pad + body;
    k = 0;

    if (!fmt.left_justify) begin
      for (int i = 0; i < pad; i++, k++)
        text_q.push_back('{ch: pad_ch, last: k == total - 1});
    end
    for (int i = body; i > 0; i--, k++) begin
      pos = i - 1;
      ch = (pos < ndig) ? udf_pkg::CHAR_ZERO + udf_pkg::CHAR_W'(digits[pos]) :
           udf_pkg::CHAR_ZERO;
      text_q.push_back('{ch: ch, last: k == total - 1});
    end
    if (fmt.left_justify) begin
      for (int i = 0; i < pad; i++, k++)
        text_q.push_back('{ch: udf_pkg::CHAR_SPACE, last: k == total - 1});
    end
  endtask

  always @(posedge clk) begin
    char_beat_t want;
    if (rst) begin
      fmt = '{precision: udf_pkg::PRECISION_RESET, field_width: 6'd0, zero_pad: 1'b0,
              left_justify: 1'b0, size_mode: udf_pkg::SIZE_MODE_RESET};
      text_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        char_n++;
        if (text_q.size() == 0) begin
          err_n++;
          if (err_n <= 10)
            $display("%t: unexpected char beat 0x%02h last=%0b", $realtime, m_tdata, m_tlast);
        end else begin
          want = text_q.pop_front();
          if (m_tdata !== want.ch || m_tlast !== want.last) begin
            err_n++;
            if (err_n <= 10)
              $display("%t: char mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       $realtime, want.ch, want.last, m_tdata, m_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          udf_pkg::REG_PRECISION:    fmt.precision    = cfg_data;
          udf_pkg::REG_FIELD_WIDTH:  fmt.field_width  = cfg_data[5:0];
          udf_pkg::REG_ZERO_PAD:     fmt.zero_pad     = cfg_data[0];
          udf_pkg::REG_LEFT_JUSTIFY: fmt.left_justify = cfg_data[0];
          udf_pkg::REG_SIZE_MODE:    fmt.size_mode    = cfg_data[1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        value_n++;
        render_value(s_tdata);
      end
    end
    mismatches  <= err_n;
    pending     <= text_q.size();
    values_seen <= value_n;
    chars_seen  <= char_n;
  end

endmodule

/* tb/unsigned_decimal_field_formatter_top_test.sv */
module unsigned_decimal_field_formatter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SETTLE_CYCLES = 200;
  localparam int         QUIET_LIMIT   = 5000;
  localparam logic [6:0] PREC_NONE     = udf_pkg::PRECISION_RESET;
  localparam logic [1:0] SIZE_64       = 2'd2;
  localparam logic [1:0] SIZE_64_DEF   = udf_pkg::SIZE_MODE_RESET;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [udf_pkg::VALUE_W-1:0]    s_tdata   = '0;   // [63:0] value
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [udf_pkg::CHAR_W-1:0]     m_tdata;          // [7:0] char_out
  logic                           m_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [udf_pkg::CFG_IDX_W-1:0]  cfg_index = udf_pkg::REG_PRECISION;
  logic [udf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int pending;
  int values_seen;
  int chars_seen;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int settings_n     = 0;
  int quiet_cycles   = 0;

  always #2 clk = ~clk;

  unsigned_decimal_field_formatter_top i_dut (.*);

  udf_field_checker i_checker (.*);

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No handshake for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // tvalid stays high on return so the next value can follow without a gap
  task automatic send_value(input logic [udf_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold off until every character is out, then let a zero-length field finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [udf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [udf_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_fmt(input logic [6:0] prec, input logic [5:0] width,
                           input logic zp, input logic lj, input logic [1:0] sm);
    settle();
    write_reg(udf_pkg::REG_PRECISION, prec);
    write_reg(udf_pkg::REG_FIELD_WIDTH, {1'b0, width});
    write_reg(udf_pkg::REG_ZERO_PAD, {6'd0, zp});
    write_reg(udf_pkg::REG_LEFT_JUSTIFY, {6'd0, lj});
    write_reg(udf_pkg::REG_SIZE_MODE, {5'd0, sm});
    // unmapped index: must leave the registers alone
    write_reg(udf_pkg::REG_SIZE_MODE + udf_pkg::CFG_IDX_W'($urandom_range(1, 3)),
              udf_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    settings_n++;
  endtask

  task automatic random_fmt();
    logic [6:0] prec;
    logic [5:0] width;
    case ($urandom_range(4))
      0: prec = PREC_NONE;
      1: prec = 7'h40 + 7'($urandom_range(0, 62));
      2: prec = 7'd0;
      3: prec = 7'd63;
      default: prec = 7'($urandom_range(0, 63));
    endcase
    case ($urandom_range(3))
      0: width = 6'd0;
      1: width = 6'd63;
      2: width = 6'($urandom_range(0, 25));
      default: width = 6'($urandom_range(0, 63));
    endcase
    apply_fmt(prec, width, 1'($urandom), 1'($urandom), 2'($urandom));
  endtask

  function automatic logic [udf_pkg::VALUE_W-1:0] random_value();
    logic [udf_pkg::VALUE_W-1:0] p;
    p = 64'd1;
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return udf_pkg::VALUE_W'($urandom_range(0, 999));
      2: return '0;
      3: begin
        repeat ($urandom_range(0, 19)) p = p * 10;
        return p - udf_pkg::VALUE_W'($urandom_range(0, 1));
      end
      4: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return '1;
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apply_fmt(PREC_NONE, 6'd0, 1'b0, 1'b0, SIZE_64_DEF);
    send_value('0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value('1);
    send_value(64'd10000000000000000000);

    apply_fmt(PREC_NONE, 6'd0, 1'b0, 1'b0, udf_pkg::SIZE_8);
    send_value(64'hFFFF_FFFF_FFFF_FF05);
    send_value('1);
    apply_fmt(PREC_NONE, 6'd0, 1'b0, 1'b0, udf_pkg::SIZE_16);
    send_value('1);

    // zero at precision 0 has no digits; with no width nothing comes out
    apply_fmt(7'd0, 6'd0, 1'b0, 1'b0, SIZE_64);
    send_value('0);
    send_value(64'd7);
    apply_fmt(7'd0, 6'd5, 1'b0, 1'b1, SIZE_64);
    send_value('0);

    // zero flag is dropped once a precision is given or padding goes right
    apply_fmt(7'd10, 6'd15, 1'b1, 1'b0, SIZE_64_DEF);
    send_value(64'd42);
    apply_fmt(PREC_NONE, 6'd8, 1'b1, 1'b1, SIZE_64_DEF);
    send_value(64'd123);
    apply_fmt(PREC_NONE, 6'd63, 1'b1, 1'b0, SIZE_64_DEF);
    send_value(64'd1);
    send_value('1);
    apply_fmt(7'd63, 6'd63, 1'b0, 1'b0, SIZE_64_DEF);
    send_value('1);
    send_value('0);

    // negative precisions other than -1 also count as not given
    apply_fmt(7'h40, 6'd4, 1'b1, 1'b0, SIZE_64_DEF);
    send_value(64'd5);
    apply_fmt(7'h7E, 6'd63, 1'b0, 1'b1, SIZE_64_DEF);
    send_value('0);

    for (int mode = 0; mode < 4; mode++) begin
      settle();
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 80; end
        default: begin send_idle_pct = 10; recv_stall_pct <= 10; end
      endcase
      for (int c = 0; c < 5; c++) begin
        random_fmt();
        for (int n = 0; n < 20; n++) begin
          if ($urandom_range(39) == 0) settle();
          send_value(random_value());
        end
      end
    end

    settle();
    $display("Formatted %0d values into %0d characters under %0d format settings,",
             values_seen, chars_seen, settings_n);
    $display("with free-running, sender-gapped, receiver-stalled and mixed pacing.");
    if (pending != 0) $display("%0d expected characters never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
